@@ src/clcd_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants for the character-LCD command generator.
// No dependencies.
package clcd_pkg;

  typedef enum logic [1:0] {
    FUNC_INIT   = 2'd0,
    FUNC_CLEAR  = 2'd1,
    FUNC_CHAR   = 2'd2,
    FUNC_NUMBER = 2'd3
  } func_t;

  localparam logic [7:0] CMD_FUNCTION_SET = 8'h38;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] LINE0_BASE       = 8'h80;
  localparam logic [7:0] LINE1_BASE       = 8'hC0;
  localparam logic [7:0] ASCII_ZERO       = 8'h30;
  localparam logic [4:0] NUMBER_BASE      = 5'd10;

  localparam logic RS_COMMAND = 1'b0;
  localparam logic RS_DATA    = 1'b1;

endpackage

@@ src/char_lcd_command_generator.sv @@
`timescale 1ns / 1ps
// Character-LCD command generator: one request in, a run of bus write words out.
// Depends on clcd_pkg.
//
//   channel | handshake          | word
//   --------+--------------------+-------------------------------------------------
//   in      | in_valid/in_ready  | func, row, column, char_code, number_value, digit_count
//   out     | out_valid/out_ready| reg_select, bus_byte, last_of_run
//
// One request at a time; in_ready is high only between requests.
// A request is accepted while idle. Init then emits 4 words, clear 1, char 2.
// Number first runs the bit-serial divide-by-ten loop (one quotient bit per cycle,
// digit_count capped at MAX_DIGITS), then emits an address word and a data word per digit.
// Output stalls hold the sequencer outside the divide loop; reset (rst, synchronous) empties the output register.
module char_lcd_command_generator
  import clcd_pkg::*;
#(
  parameter int MAX_DIGITS  = 10,
  parameter int NUMBER_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic        row,
  input  logic [5:0]  column,
  input  logic [7:0]  char_code,
  input  logic [31:0] number_value,
  input  logic [3:0]  digit_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        reg_select,
  output logic [7:0]  bus_byte,
  output logic        last_of_run
);

  localparam int DW = $clog2(MAX_DIGITS + 1);
  localparam int BW = $clog2(NUMBER_BITS);
  localparam logic [BW-1:0] BIT_LAST = BW'(NUMBER_BITS - 1);
  localparam logic [3:0]    MAX_CNT  = 4'(MAX_DIGITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_CLEAR,
    S_CHAR_ADDR,
    S_CHAR_DATA,
    S_DIV,
    S_NUM_ADDR,
    S_NUM_DATA
  } state_t;

  state_t                 state;
  logic [1:0]             step;
  logic [7:0]             addr;
  logic [7:0]             chr;
  logic [NUMBER_BITS-1:0] value;
  logic [3:0]             rem;
  logic [BW-1:0]          bit_cnt;
  logic [DW-1:0]          cnt;
  logic [DW-1:0]          dig_cnt;
  logic [3:0]             digits [MAX_DIGITS];

  logic                   out_free;
  logic                   word_load;
  logic                   accept;
  logic [4:0]             trial;
  logic                   q_bit;
  logic [3:0]             rem_next;
  logic [7:0]             addr_start;
  logic [DW-1:0]          cnt_in;
  logic [7:0]             init_byte;
  logic                   dig_last;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign word_load = out_free && (state != S_IDLE) && (state != S_DIV);

  assign trial     = {rem, value[NUMBER_BITS-1]};
  assign q_bit     = (trial >= NUMBER_BASE);
  assign rem_next  = q_bit ? 4'(trial - NUMBER_BASE) : trial[3:0];

  assign addr_start = (row ? LINE1_BASE : LINE0_BASE) + {2'b00, column};
  assign cnt_in     = (digit_count > MAX_CNT) ? DW'(MAX_DIGITS) : DW'(digit_count);
  assign dig_last   = ((dig_cnt + DW'(1)) == cnt);

  always_comb begin
    unique case (step)
      2'd0:    init_byte = CMD_FUNCTION_SET;
      2'd1:    init_byte = CMD_DISPLAY_ON;
      2'd2:    init_byte = CMD_ENTRY_MODE;
      default: init_byte = CMD_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      step      <= '0;
      bit_cnt   <= '0;
      dig_cnt   <= '0;
    end else begin
      if (word_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            addr    <= addr_start;
            chr     <= char_code;
            value   <= number_value[NUMBER_BITS-1:0];
            rem     <= '0;
            cnt     <= cnt_in;
            step    <= '0;
            bit_cnt <= '0;
            dig_cnt <= '0;
            unique case (func_t'(func))
              FUNC_INIT:   state <= S_INIT;
              FUNC_CLEAR:  state <= S_CLEAR;
              FUNC_CHAR:   state <= S_CHAR_ADDR;
              FUNC_NUMBER: state <= (cnt_in == '0) ? S_IDLE : S_DIV;
              default:     state <= S_IDLE;
            endcase
          end
        end
        S_INIT: begin
          if (out_free) begin
            reg_select  <= RS_COMMAND;
            bus_byte    <= init_byte;
            last_of_run <= (step == 2'd3);
            step        <= step + 2'd1;
            if (step == 2'd3) begin
              state <= S_IDLE;
            end
          end
        end
        S_CLEAR: begin
          if (out_free) begin
            reg_select  <= RS_COMMAND;
            bus_byte    <= CMD_CLEAR;
            last_of_run <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_CHAR_ADDR: begin
          if (out_free) begin
            reg_select  <= RS_COMMAND;
            bus_byte    <= addr;
            last_of_run <= 1'b0;
            state       <= S_CHAR_DATA;
          end
        end
        S_CHAR_DATA: begin
          if (out_free) begin
            reg_select  <= RS_DATA;
            bus_byte    <= chr;
            last_of_run <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_DIV: begin
          // restoring divide by ten, one quotient bit per cycle
          value <= {value[NUMBER_BITS-2:0], q_bit};
          if (bit_cnt == BIT_LAST) begin
            bit_cnt   <= '0;
            rem       <= '0;
            digits[0] <= rem_next;
            for (int i = 1; i < MAX_DIGITS; i++) begin
              digits[i] <= digits[i-1];
            end
            if (dig_last) begin
              dig_cnt <= '0;
              state   <= S_NUM_ADDR;
            end else begin
              dig_cnt <= dig_cnt + DW'(1);
            end
          end else begin
            bit_cnt <= bit_cnt + BW'(1);
            rem     <= rem_next;
          end
        end
        S_NUM_ADDR: begin
          if (out_free) begin
            reg_select  <= RS_COMMAND;
            bus_byte    <= addr;
            last_of_run <= 1'b0;
            state       <= S_NUM_DATA;
          end
        end
        S_NUM_DATA: begin
          if (out_free) begin
            reg_select  <= RS_DATA;
            bus_byte    <= ASCII_ZERO + {4'b0000, digits[0]};
            last_of_run <= dig_last;
            addr        <= addr + 8'd1;
            dig_cnt     <= dig_cnt + DW'(1);
            for (int i = 0; i < MAX_DIGITS - 1; i++) begin
              digits[i] <= digits[i+1];
            end
            digits[MAX_DIGITS-1] <= '0;
            state <= dig_last ? S_IDLE : S_NUM_ADDR;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ test/lcd_write_checker.sv @@
`timescale 1ns / 1ps
// Checker for the character-LCD command generator: watches both channels, works out
// the bus write words each accepted request should cause and compares them in order.
// Depends on clcd_pkg.
module lcd_write_checker
  import clcd_pkg::*;
#(
  parameter int MAX_DIGITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  func,
  input  logic        row,
  input  logic [5:0]  column,
  input  logic [7:0]  char_code,
  input  logic [31:0] number_value,
  input  logic [3:0]  digit_count,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        reg_select,
  input  logic [7:0]  bus_byte,
  input  logic        last_of_run,
  output int          mismatch_count,
  output int          outstanding
);

  typedef struct packed {
    logic       rs;
    logic [7:0] data;
    logic       last;
  } bus_write_t;

  bus_write_t pending_writes[$];

  task automatic predict_writes(input func_t f, input logic r, input logic [5:0] col,
                                input logic [7:0] ch, input logic [31:0] val,
                                input logic [3:0] cnt);
    bus_write_t run[$];
    logic [7:0] line_base;
    logic [3:0] digit[MAX_DIGITS];
    logic [31:0] rest;
    int ndigits;
    line_base = r ? LINE1_BASE : LINE0_BASE;
    case (f)
      FUNC_INIT: begin
        run.push_back('{RS_COMMAND, CMD_FUNCTION_SET, 1'b0});
        run.push_back('{RS_COMMAND, CMD_DISPLAY_ON, 1'b0});
        run.push_back('{RS_COMMAND, CMD_ENTRY_MODE, 1'b0});
        run.push_back('{RS_COMMAND, CMD_CLEAR, 1'b0});
      end
      FUNC_CLEAR: begin
        run.push_back('{RS_COMMAND, CMD_CLEAR, 1'b0});
      end
      FUNC_CHAR: begin
        run.push_back('{RS_COMMAND, 8'(line_base + col), 1'b0});
        run.push_back('{RS_DATA, ch, 1'b0});
      end
      FUNC_NUMBER: begin
        ndigits = (cnt > MAX_DIGITS) ? MAX_DIGITS : int'(cnt);
        rest = val;
        // low digits first into the array, most significant ends at index 0
        for (int i = ndigits - 1; i >= 0; i--) begin
          digit[i] = 4'(rest % 10);
          rest     = rest / 10;
        end
        for (int i = 0; i < ndigits; i++) begin
          run.push_back('{RS_COMMAND, 8'(line_base + col + i), 1'b0});
          run.push_back('{RS_DATA, 8'(ASCII_ZERO + digit[i]), 1'b0});
        end
      end
      default: ;
    endcase
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[k]) pending_writes.push_back(run[k]);
  endtask

  always @(posedge clk) begin
    bus_write_t seen;
    bus_write_t want;
    if (rst) begin
      pending_writes.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen = '{reg_select, bus_byte, last_of_run};
        if (pending_writes.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected word rs=%0b byte=%02h last=%0b",
                   $time, seen.rs, seen.data, seen.last);
        end else begin
          want = pending_writes.pop_front();
          if (seen !== want) begin
            mismatch_count++;
            $display("%0t: mismatch expected rs=%0b byte=%02h last=%0b, %s",
                     $time, want.rs, want.data, want.last,
                     $sformatf("got rs=%0b byte=%02h last=%0b",
                               seen.rs, seen.data, seen.last));
          end
        end
      end
      if (in_valid && in_ready)
        predict_writes(func_t'(func), row, column, char_code, number_value, digit_count);
    end
    outstanding <= pending_writes.size();
  end

endmodule

@@ test/char_lcd_command_generator_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the character-LCD command generator: directed and random requests
// with random idling on both channels; lcd_write_checker does the prediction.
// Depends on clcd_pkg, char_lcd_command_generator and lcd_write_checker.
module char_lcd_command_generator_tb;
  import clcd_pkg::*;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  func_t       func         = FUNC_INIT;
  logic        row          = 1'b0;
  logic [5:0]  column       = '0;
  logic [7:0]  char_code    = '0;
  logic [31:0] number_value = '0;
  logic [3:0]  digit_count  = '0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic        reg_select;
  logic [7:0]  bus_byte;
  logic        last_of_run;

  int mismatch_count;
  int outstanding;
  bit calm      = 1'b0;
  bit stall_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  char_lcd_command_generator uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .row(row), .column(column), .char_code(char_code),
    .number_value(number_value), .digit_count(digit_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .reg_select(reg_select), .bus_byte(bus_byte), .last_of_run(last_of_run)
  );

  lcd_write_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .row(row), .column(column), .char_code(char_code),
    .number_value(number_value), .digit_count(digit_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .reg_select(reg_select), .bus_byte(bus_byte), .last_of_run(last_of_run),
    .mismatch_count(mismatch_count), .outstanding(outstanding)
  );

  task automatic send_request(input func_t f, input logic r, input logic [5:0] col,
                              input logic [7:0] ch, input logic [31:0] val,
                              input logic [3:0] cnt);
    while (!calm && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= f;
    row          <= r;
    column       <= col;
    char_code    <= ch;
    number_value <= val;
    digit_count  <= cnt;
    do @(posedge clk); while (!in_ready);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 28);
      end
    end
  end

  initial begin
    logic [31:0] val;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: unused fields carry junk on init and clear
    send_request(FUNC_INIT,   1'b1, 6'd63, 8'hFF, 32'hFFFF_FFFF, 4'd15);
    send_request(FUNC_CLEAR,  1'b1, 6'd63, 8'hFF, 32'hFFFF_FFFF, 4'd15);
    send_request(FUNC_CHAR,   1'b0, 6'd0,  8'h00, 32'h0,         4'd0);
    send_request(FUNC_CHAR,   1'b1, 6'd63, 8'hFF, 32'hFFFF_FFFF, 4'd15);
    send_request(FUNC_CHAR,   1'b0, 6'd39, 8'h41, 32'h0,         4'd0);
    send_request(FUNC_CHAR,   1'b1, 6'd0,  8'h80, 32'h0,         4'd0);
    send_request(FUNC_NUMBER, 1'b0, 6'd3,  8'h00, 32'd12345,     4'd0);
    send_request(FUNC_NUMBER, 1'b0, 6'd0,  8'h00, 32'd7,         4'd1);
    send_request(FUNC_NUMBER, 1'b0, 6'd0,  8'hFF, 32'hFFFF_FFFF, 4'd10);
    send_request(FUNC_NUMBER, 1'b1, 6'd30, 8'h00, 32'd0,         4'd10);
    send_request(FUNC_NUMBER, 1'b0, 6'd5,  8'h00, 32'd1234567890, 4'd15);
    send_request(FUNC_NUMBER, 1'b1, 6'd2,  8'h00, 32'd4000000000, 4'd11);
    send_request(FUNC_NUMBER, 1'b1, 6'd63, 8'h00, 32'd1234567890, 4'd10);
    send_request(FUNC_NUMBER, 1'b0, 6'd10, 8'h00, 32'd987654,    4'd3);
    send_request(FUNC_NUMBER, 1'b0, 6'd63, 8'h00, 32'd42,        4'd5);
    send_request(FUNC_INIT,   1'b0, 6'd0,  8'h00, 32'h0,         4'd0);
    send_request(FUNC_CLEAR,  1'b0, 6'd0,  8'h00, 32'h0,         4'd0);
    send_request(FUNC_CHAR,   1'b0, 6'd42, 8'h55, 32'hA5A5_5A5A, 4'd9);

    for (int n = 0; n < 110; n++) begin
      calm = (n >= 20 && n < 45);
      if (n == 50) stall_req = 1'b1;
      if (n == 75) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
      end
      case ($urandom_range(0, 3))
        0:       val = $urandom;
        1:       val = $urandom_range(0, 999);
        2:       val = 32'hFFFF_FFFF - $urandom_range(0, 9);
        default: val = $urandom >> $urandom_range(0, 31);
      endcase
      send_request(func_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)), val,
                   ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(0, 5)));
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (400) @(posedge clk);
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ sim.f @@
src/clcd_pkg.sv
src/char_lcd_command_generator.sv
test/lcd_write_checker.sv
test/char_lcd_command_generator_tb.sv
